>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge while out of reset.
`define DCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DCR_ASSERT_IMPL(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/dcr_pkg.sv
// Shared types, constants and the answer record table of the DNS responder.
package dcr_pkg;

    localparam int HDR_LEN     = 12;   // DNS header length, first label offset
    localparam int OFS_FLAGS_HI = 2;
    localparam int OFS_FLAGS_LO = 3;
    localparam int OFS_ANCNT_HI = 6;
    localparam int OFS_ANCNT_LO = 7;
    localparam int QTAIL_LEN   = 5;    // null label + QTYPE + QCLASS
    localparam int ANSWER_LEN  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] FLAGS_HI_BYTE = 8'h81;
    localparam logic [7:0] FLAGS_LO_BYTE = 8'h80;
    localparam logic [7:0] ANCNT_HI_BYTE = 8'h00;
    localparam logic [7:0] ANCNT_LO_BYTE = 8'h01;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_ANSWER,
        CMD_DROP
    } cmd_t;

    // One queue word: an optional echoed byte plus an end-of-datagram command.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        cmd_t       cmd;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Byte idx of the appended A record.
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] addr);
        logic [7:0] res;
        case (idx)
            4'd0:    res = 8'hc0;
            4'd1:    res = 8'h0c;
            4'd2:    res = 8'h00;
            4'd3:    res = 8'h01;
            4'd4:    res = 8'h00;
            4'd5:    res = 8'h01;
            4'd6:    res = 8'h00;
            4'd7:    res = 8'h00;
            4'd8:    res = 8'h00;
            4'd9:    res = 8'h3c;
            4'd10:   res = 8'h00;
            4'd11:   res = 8'h04;
            4'd12:   res = addr[31:24];
            4'd13:   res = addr[23:16];
            4'd14:   res = addr[15:8];
            4'd15:   res = addr[7:0];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

>>> sv/dcr_front.sv
// Front end: accepts query bytes, walks the question labels, queues words.
module dcr_front #(
    parameter int MAX_DATAGRAM = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_query_byte,
    input  logic               s_query_last,
    input  logic               q_full,
    output logic               q_push,
    output dcr_pkg::q_entry_t  q_wdata
);
    import dcr_pkg::*;

    localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
    localparam int LP_W  = $clog2(MAX_DATAGRAM + 257);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LP_W-1:0]  lptr_reg, lptr_next;
    logic             term_reg, term_next;
    logic [LP_W-1:0]  qend_reg, qend_next;

    logic             take;
    logic             in_range;
    logic             emit;
    logic             bad;
    logic [POS_W-1:0] len;
    logic [7:0]       obyte;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    always_comb begin
        pos_next  = pos_reg;
        lptr_next = lptr_reg;
        term_next = term_reg;
        qend_next = qend_reg;
        in_range  = pos_reg < POS_W'(MAX_DATAGRAM);
        obyte     = s_query_byte;
        emit      = 1'b0;

        if (in_range) begin
            if (pos_reg >= POS_W'(HDR_LEN) && !term_reg && LP_W'(pos_reg) == lptr_reg) begin
                if (s_query_byte == 8'h00) begin
                    term_next = 1'b1;
                    qend_next = LP_W'(pos_reg) + LP_W'(QTAIL_LEN);
                end else begin
                    lptr_next = LP_W'(pos_reg) + LP_W'(s_query_byte) + LP_W'(1);
                end
            end
            if (pos_reg == POS_W'(OFS_FLAGS_HI)) begin
                obyte = FLAGS_HI_BYTE;
            end else if (pos_reg == POS_W'(OFS_FLAGS_LO)) begin
                obyte = FLAGS_LO_BYTE;
            end else if (pos_reg == POS_W'(OFS_ANCNT_HI)) begin
                obyte = ANCNT_HI_BYTE;
            end else if (pos_reg == POS_W'(OFS_ANCNT_LO)) begin
                obyte = ANCNT_LO_BYTE;
            end
            emit     = (pos_reg < POS_W'(HDR_LEN)) || !term_next
                       || (LP_W'(pos_reg) < qend_next);
            pos_next = pos_reg + POS_W'(1);
        end

        len = pos_next;
        bad = (len < POS_W'(HDR_LEN)) || !term_next || (qend_next > LP_W'(len));

        q_wdata.data     = obyte;
        q_wdata.has_byte = emit;
        q_wdata.cmd      = CMD_NONE;
        if (s_query_last) begin
            if (bad) begin
                q_wdata.has_byte = 1'b0;
                q_wdata.cmd      = CMD_DROP;
            end else begin
                q_wdata.cmd = CMD_ANSWER;
            end
            pos_next  = '0;
            lptr_next = LP_W'(HDR_LEN);
            term_next = 1'b0;
            qend_next = '0;
        end
        q_push = take && (emit || s_query_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            lptr_reg <= LP_W'(HDR_LEN);
            term_reg <= 1'b0;
            qend_reg <= '0;
        end else if (take) begin
            pos_reg  <= pos_next;
            lptr_reg <= lptr_next;
            term_reg <= term_next;
            qend_reg <= qend_next;
        end
    end

endmodule

>>> sv/dcr_queue.sv
// Short word queue between the front and back ends.
module dcr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dcr_pkg::q_entry_t  wdata,
    input  logic               pop,
    output dcr_pkg::q_entry_t  rdata,
    output dcr_pkg::q_stat_t   stat
);
    import dcr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign rdata      = mem[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> sv/dcr_back.sv
// Back end: drains queue words into reply bytes and plays out the A record.
module dcr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  dcr_pkg::q_entry_t  q_rdata,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [31:0]        answer_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_reply_byte,
    output logic               m_reply_last,
    output logic               m_reply_drop
);
    import dcr_pkg::*;

    localparam int IDX_W = $clog2(ANSWER_LEN);

    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             drop_reg, drop_next;
    logic             ans_reg, ans_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             load;

    assign m_valid      = valid_reg;
    assign m_reply_byte = byte_reg;
    assign m_reply_last = last_reg;
    assign m_reply_drop = drop_reg;
    assign load         = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        ans_next   = ans_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = 1'b0;
            if (ans_reg) begin
                valid_next = 1'b1;
                byte_next  = answer_byte(idx_reg, answer_address);
                last_next  = idx_reg == IDX_W'(ANSWER_LEN - 1);
                drop_next  = 1'b0;
                if (idx_reg == IDX_W'(ANSWER_LEN - 1)) begin
                    ans_next = 1'b0;
                end
                idx_next = idx_reg + IDX_W'(1);
            end else if (!q_empty) begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                drop_next  = 1'b0;
                last_next  = 1'b0;
                case (q_rdata.cmd)
                    CMD_DROP: begin
                        byte_next = 8'h00;
                        last_next = 1'b1;
                        drop_next = 1'b1;
                    end
                    CMD_ANSWER: begin
                        ans_next = 1'b1;
                        if (q_rdata.has_byte) begin
                            byte_next = q_rdata.data;
                            idx_next  = '0;
                        end else begin
                            byte_next = answer_byte('0, answer_address);
                            idx_next  = IDX_W'(1);
                        end
                    end
                    default: begin
                        byte_next = q_rdata.data;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ans_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ans_reg   <= ans_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        drop_reg <= drop_next;
    end

endmodule

>>> sv/dns_captive_responder_unit.sv
// Top level of the captive-portal DNS responder: front end, queue, back end.
//
// Usage:
//  - s_ takes one query word per cycle if ready: s_query_byte, s_query_last on
//    the datagram's final byte. m_ channel gives reply words: m_reply_byte,
//    m_reply_last on the final word of a reply, m_reply_drop on a drop marker.
//  - cfg channel writes answer_address; always ready. Write it only while idle.
//  - Header bytes 2/3/6/7 are patched, question echoed, trailing bytes dropped,
//    a 16-byte A record follows a good query. A bad one ends with a single
//    drop marker (byte 0, last 1); downstream throws away what it already got.
//  - Path: an accepted word is queued, then shows on m_ from the output register.
//  - Throughput: one word per cycle while the queue has room; the back end
//    pops nothing while it plays out a 16-byte answer record, so the 4-word
//    queue can fill and s_ready stay low after the final byte of a good query.
//  - Receiver stall: the output register holds, the back end stops popping,
//    the queue fills and s_ready falls; nothing is lost.
//  - Reset (aresetn low, synchronous): queue emptied, walk state cleared,
//    answer_address set to 0, no reply word pending.
//  - Bytes past MAX_DATAGRAM are swallowed; their final flag still counts.
`include "assert_macros.svh"

module dns_captive_responder_unit #(
    parameter int MAX_DATAGRAM = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // query bytes in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_query_byte,
    input  logic        s_query_last,
    // reply bytes out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_reply_byte,
    output logic        m_reply_last,
    output logic        m_reply_drop,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_answer_address
);
    import dcr_pkg::*;

    logic [31:0] addr_reg;
    logic        q_push;
    logic        q_pop;
    q_entry_t    q_wdata;
    q_entry_t    q_rdata;
    q_stat_t     q_stat;

    // Config register: one word, taken every cycle it is offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            addr_reg <= cfg_answer_address;
        end
    end

    // Front: label walk and header patch, one word per cycle while the queue has room.
    dcr_front #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_query_byte (s_query_byte),
        .s_query_last (s_query_last),
        .q_full       (q_stat.full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    // Decoupling queue.
    dcr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    // Back: reply word register plus answer record sequencer.
    dcr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_rdata        (q_rdata),
        .q_empty        (q_stat.empty),
        .q_pop          (q_pop),
        .answer_address (addr_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reply_byte   (m_reply_byte),
        .m_reply_last   (m_reply_last),
        .m_reply_drop   (m_reply_drop)
    );

    // A drop marker always closes the reply and carries a zero byte.
    `DCR_ASSERT_IMPL(a_drop_marker, m_valid && m_reply_drop, m_reply_last && m_reply_byte == 8'h00, "drop marker malformed")
    // The back end never pops an empty queue.
    `DCR_ASSERT_IMPL(a_no_underflow, q_pop, !q_stat.empty, "queue underflow")
    // The front end never pushes into a full queue.
    `DCR_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full, "queue overflow")

endmodule

>>> test/dns_captive_responder_unit_tb.sv
// Self-checking testbench of the captive-portal DNS responder: random query datagrams, scoreboard.
`timescale 1ns / 100ps

module dns_captive_responder_unit_tb;
    import dcr_pkg::*;

    localparam int MAX_DGRAM     = 512;      // datagram cap of the block, default value
    localparam int RANDOM_WORDS  = 210;      // query words in the random part
    localparam int DRAIN_CYCLES  = 24;       // margin for in-flight words plus a full answer record
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_GAP       = 14;
    localparam int DGRAMS_PER_PHASE = 2;

    // One reply word as seen on the m_ side.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } reply_word_t;

    typedef enum {
        DG_GOOD,        // well-formed query, maybe with trailing bytes
        DG_WIDE_LABEL,  // well-formed, first label long
        DG_CUT,         // well-formed query cut short
        DG_SHORT,       // fewer than a header's worth of bytes
        DG_NOISE        // random bytes after a random header
    } dgram_kind_t;

    // Tracks the question walk and holds the reply words still owed by the block.
    class reply_scoreboard;
        logic [31:0] answer_address;
        logic [9:0]  byte_position;
        logic [10:0] label_pointer;
        logic        terminator_seen;
        logic [10:0] question_end;
        reply_word_t expected_replies[$];
        int          failures;

        function new();
            answer_address = '0;
            failures = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            byte_position   = '0;
            label_pointer   = 11'(HDR_LEN);
            terminator_seen = 1'b0;
            question_end    = '0;
        endfunction

        function void set_address(logic [31:0] value);
            answer_address = value;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_query(logic [7:0] value, logic last);
            logic [7:0]  record_head [12];
            logic [9:0]  pos;
            logic [7:0]  echoed;
            logic        emit;
            logic        bad;
            int          i;
            record_head = '{8'hc0, 8'h0c, 8'h00, 8'h01, 8'h00, 8'h01,
                            8'h00, 8'h00, 8'h00, 8'h3c, 8'h00, 8'h04};
            pos    = byte_position;
            echoed = value;
            emit   = 1'b0;
            if (pos < MAX_DGRAM) begin
                // label walk: a length byte at the pointer either ends the name or skips a label
                if (pos >= HDR_LEN && !terminator_seen && pos == label_pointer) begin
                    if (value == 8'h00) begin
                        terminator_seen = 1'b1;
                        question_end    = 11'(pos) + 11'(QTAIL_LEN);
                    end else begin
                        label_pointer = 11'(pos) + 11'(value) + 11'd1;
                    end
                end
                case (pos)
                    OFS_FLAGS_HI: echoed = FLAGS_HI_BYTE;
                    OFS_FLAGS_LO: echoed = FLAGS_LO_BYTE;
                    OFS_ANCNT_HI: echoed = ANCNT_HI_BYTE;
                    OFS_ANCNT_LO: echoed = ANCNT_LO_BYTE;
                    default: ;
                endcase
                emit = (pos < HDR_LEN) || !terminator_seen || (pos < question_end);
                byte_position = pos + 10'd1;
            end
            if (!last) begin
                if (emit)
                    expected_replies.push_back('{echoed, 1'b0, 1'b0});
                return;
            end
            bad = (byte_position < HDR_LEN) || !terminator_seen ||
                  (question_end > byte_position);
            if (bad) begin
                expected_replies.push_back('{8'h00, 1'b1, 1'b1});
            end else begin
                if (emit)
                    expected_replies.push_back('{echoed, 1'b0, 1'b0});
                for (i = 0; i < 12; i++)
                    expected_replies.push_back('{record_head[i], 1'b0, 1'b0});
                expected_replies.push_back('{answer_address[31:24], 1'b0, 1'b0});
                expected_replies.push_back('{answer_address[23:16], 1'b0, 1'b0});
                expected_replies.push_back('{answer_address[15:8], 1'b0, 1'b0});
                expected_replies.push_back('{answer_address[7:0], 1'b1, 1'b0});
            end
            clear_walk();
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_reply(logic [7:0] value, logic last, logic drop);
            reply_word_t want;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply word, expected none, actual %02h last %0b drop %0b",
                         $time, value, last, drop);
                failures++;
                return;
            end
            want = expected_replies.pop_front();
            compare_field("reply_byte", want.data, value);
            compare_field("reply_last", {7'd0, want.last}, {7'd0, last});
            compare_field("reply_drop", {7'd0, want.drop}, {7'd0, drop});
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_query_byte;
    logic        s_query_last;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_reply_byte;
    logic        m_reply_last;
    logic        m_reply_drop;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_answer_address;

    reply_scoreboard board;
    logic [7:0]      dgram[$];      // datagram being built for the sender
    int              sent_words;
    int              cycle_count;
    int              rx_stall;      // cycles m_ready stays low before the next word
    bit              tx_burst;      // sender runs back to back
    bit              rx_burst;      // receiver never stalls

    dns_captive_responder_unit #(
        .MAX_DATAGRAM(MAX_DGRAM)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_query_byte       (s_query_byte),
        .s_query_last       (s_query_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_reply_byte       (m_reply_byte),
        .m_reply_last       (m_reply_last),
        .m_reply_drop       (m_reply_drop),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_answer_address (cfg_answer_address)
    );

    always #1 aclk = ~aclk;

    // Receiver side: hold m_ready low for the stall drawn at the last accepted word.
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Everything is sampled at the rising edge; inputs are noted before outputs are
    // checked so a same-cycle reply would still find its expectation.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d reply words still expected", $time, board.pending());
            $display("Some tests failed");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready)
                board.set_address(cfg_answer_address);
            if (s_valid && s_ready)
                board.note_query(s_query_byte, s_query_last);
            if (m_valid && m_ready) begin
                board.check_reply(m_reply_byte, m_reply_last, m_reply_drop);
                rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    // Valid only drops when a gap is drawn, so back-to-back words keep it high.
    task automatic send_word(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_query_byte <= value;
        s_query_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_words++;
        @(negedge aclk);
    endtask

    task automatic send_datagram();
        int i;
        for (i = 0; i < dgram.size(); i++)
            send_word(dgram[i], i == dgram.size() - 1);
    endtask

    // Quiesce: no more query words, every reply word in, then a few spare cycles
    // so nothing is in flight when the address changes.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_address(input logic [31:0] value);
        cfg_valid          <= 1'b1;
        cfg_answer_address <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random header, labels, null label, QTYPE/QCLASS, then optional trailing bytes.
    task automatic build_query(input int labels, input bit wide_first, input int trailing);
        int n;
        int len;
        dgram.delete();
        repeat (HDR_LEN) dgram.push_back(8'($urandom_range(0, 255)));
        for (n = 0; n < labels; n++) begin
            len = (wide_first && n == 0) ? $urandom_range(16, 63) : $urandom_range(1, 8);
            dgram.push_back(8'(len));
            repeat (len) dgram.push_back(8'($urandom_range(0, 255)));
        end
        dgram.push_back(8'h00);
        repeat (QTAIL_LEN - 1 + trailing) dgram.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic int draw_trailing();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
    endfunction

    initial begin
        int          random_base;
        int          phase;
        int          in_phase;
        int          pick;
        int          cut;
        logic [31:0] addr;
        dgram_kind_t kind;

        board              = new();
        aclk               = 1'b0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_query_byte       = '0;
        s_query_last       = 1'b0;
        m_ready            = 1'b0;
        cfg_valid          = 1'b0;
        cfg_answer_address = '0;
        sent_words         = 0;
        cycle_count        = 0;
        rx_stall           = 0;
        tx_burst           = 1'b0;
        rx_burst           = 1'b0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part, address still at its reset value of zero ----
        // lone zero word with last set: shortest possible datagram
        dgram = '{8'h00};
        send_datagram();
        // five all-ones words: short datagram
        dgram = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
        send_datagram();
        // root-name query, header all ones so every patched byte really changes
        dgram.delete();
        repeat (HDR_LEN) dgram.push_back(8'hff);
        dgram.push_back(8'h00);
        repeat (QTAIL_LEN - 1) dgram.push_back(8'hff);
        send_datagram();
        wait_drained();

        // ---- random part: phases of a few datagrams, new address and idling mode each ----
        random_base = sent_words;
        phase       = 0;
        in_phase    = DGRAMS_PER_PHASE;
        while (sent_words - random_base < RANDOM_WORDS) begin
            if (in_phase == DGRAMS_PER_PHASE) begin
                // pause the sender until the block has answered everything
                wait_drained();
                if (phase == 0) begin
                    addr = 32'hffff_ffff;
                end else if (phase == 1) begin
                    addr = 32'h0000_0000;
                end else begin
                    pick = $urandom_range(0, 3);
                    addr = (pick == 0) ? 32'hffff_ffff : (pick == 1) ? 32'h0 : $urandom;
                end
                write_address(addr);
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
                phase++;
                in_phase = 0;
            end
            pick = $urandom_range(0, 9);
            kind = (pick < 6) ? DG_GOOD : (pick == 6) ? DG_WIDE_LABEL :
                   (pick == 7) ? DG_CUT : (pick == 8) ? DG_SHORT : DG_NOISE;
            case (kind)
                DG_GOOD: begin
                    build_query($urandom_range(0, 3), 1'b0, draw_trailing());
                end
                DG_WIDE_LABEL: begin
                    build_query($urandom_range(1, 3), 1'b1, draw_trailing());
                end
                DG_CUT: begin
                    // anywhere from a bare header to one byte short of QCLASS
                    build_query($urandom_range(0, 3), 1'b0, 0);
                    cut = $urandom_range(HDR_LEN, dgram.size() - 1);
                    while (dgram.size() > cut) void'(dgram.pop_back());
                end
                DG_SHORT: begin
                    dgram.delete();
                    repeat ($urandom_range(1, HDR_LEN - 1))
                        dgram.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    // label bytes are random, so the walk may land anywhere or overrun
                    dgram.delete();
                    repeat ($urandom_range(HDR_LEN, 40))
                        dgram.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            send_datagram();
            in_phase++;
        end
        wait_drained();

        // ---- oversize datagram: good question, then filler past the cap ----
        write_address($urandom);
        tx_burst = 1'b1;
        rx_burst = ($urandom_range(0, 1) == 0);
        build_query(1, 1'b0, 0);
        while (dgram.size() < MAX_DGRAM + 4) dgram.push_back(8'($urandom_range(0, 255)));
        send_datagram();
        wait_drained();

        if (board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/dcr_pkg.sv
sv/dcr_front.sv
sv/dcr_queue.sv
sv/dcr_back.sv
sv/dns_captive_responder_unit.sv
test/dns_captive_responder_unit_tb.sv
